// File: sv/plst_pkg.sv
`default_nettype none

package plst_pkg;

    localparam int DEF_CAPACITY    = 16;
    localparam int DEF_VALUE_WIDTH = 32;

    // Widths of the stream fields.
    localparam int OPCODE_W = 3;
    localparam int DATA_W   = 32;
    localparam int POS_W    = 5;
    localparam int STATUS_W = 3;
    localparam int INDEX_W  = 5;
    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 48;

    typedef enum logic [OPCODE_W-1:0] {
        OP_INS_FRONT = 3'd0,
        OP_INS_BACK  = 3'd1,
        OP_INS_AT    = 3'd2,
        OP_DEL_FRONT = 3'd3,
        OP_DEL_BACK  = 3'd4,
        OP_DEL_AT    = 3'd5,
        OP_TRAVERSE  = 3'd6
    } opcode_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK     = 3'd0,
        ST_EMPTY  = 3'd1,
        ST_BADPOS = 3'd2,
        ST_SHORT  = 3'd3,
        ST_FULL   = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        FSM_IDLE,
        FSM_EXEC,
        FSM_TRAV
    } fsm_state_t;

    // What one storage cell does in a cycle.
    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_LOAD,
        CELL_SHIFT_UP,
        CELL_SHIFT_DOWN
    } cell_op_t;

endpackage

`default_nettype wire

// File: sv/plst_cell.sv
`default_nettype none

module plst_cell #(
    parameter int VALUE_WIDTH = plst_pkg::DEF_VALUE_WIDTH
) (
    input  wire logic                   aclk,
    input  wire plst_pkg::cell_op_t     cell_op,
    input  wire logic [VALUE_WIDTH-1:0] load_value,
    input  wire logic [VALUE_WIDTH-1:0] lower_value,
    input  wire logic [VALUE_WIDTH-1:0] upper_value,
    output logic [VALUE_WIDTH-1:0]      value_q
);
    import plst_pkg::*;

    logic [VALUE_WIDTH-1:0] value_reg;
    logic [VALUE_WIDTH-1:0] value_next;

    // Shifting up takes the entry from the cell below; shifting down from the cell above.
    always_comb begin
        case (cell_op)
            CELL_LOAD:       value_next = load_value;
            CELL_SHIFT_UP:   value_next = lower_value;
            CELL_SHIFT_DOWN: value_next = upper_value;
            default:         value_next = value_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        value_reg <= value_next;
    end

    assign value_q = value_reg;

endmodule

`default_nettype wire

// File: sv/positional_list_store.sv
// Ordered list store of up to CAPACITY signed values held in a row of cells.
// Input stream (s_*): one operation per transfer: insert at front, back or a
// 1-based position, delete front, back or a position, or traverse.
// Result stream (m_*): one transfer per operation, except a traverse of a
// non-empty list, which gives one transfer per entry in list order; m_tlast
// marks the final result of each operation. An unused opcode gives nothing.
// From acceptance to a registered result, an operation first latches the
// command, then decodes it, shifts the whole cell row in parallel and
// loads the output register once it is free. A traverse then emits one
// entry per cycle while the receiver is ready. One command is handled at
// a time; the sequencer sets that rate.
// The output register lets the next command be accepted while a result is
// still waiting. When the receiver stalls, the block finishes its current
// command only as far as the output register allows and then holds.
// Reset (aresetn low, synchronous) empties the list and drops any pending
// result; stored values are not cleared and are never read before written.
`default_nettype none

module positional_list_store #(
    parameter int CAPACITY    = plst_pkg::DEF_CAPACITY,
    parameter int VALUE_WIDTH = plst_pkg::DEF_VALUE_WIDTH
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    // s_tdata: opcode[2:0], item_value[34:3], list_position[39:35]
    input  wire logic [plst_pkg::S_TDATA_W-1:0] s_tdata,
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    // m_tdata: status[2:0], data_out[34:3], entry_index[39:35],
    //          entry_total[44:40], zero fill[47:45]
    output logic [plst_pkg::M_TDATA_W-1:0]      m_tdata,
    output logic                                m_tlast,
    output logic                                m_tvalid,
    input  wire logic                           m_tready
);
    import plst_pkg::*;

    localparam int CW   = $clog2(CAPACITY + 1);
    localparam int IW   = $clog2(CAPACITY);
    localparam int CMPW = ((CW > POS_W) ? CW : POS_W) + 1;
    localparam int DW   = (VALUE_WIDTH > DATA_W) ? VALUE_WIDTH : DATA_W;

    fsm_state_t state_reg, state_next;

    opcode_t                op_reg;
    logic [VALUE_WIDTH-1:0] val_reg;
    logic [POS_W-1:0]       pos_reg;
    logic [CW-1:0]          count_reg, count_next;
    logic [IW-1:0]          trav_reg, trav_next;

    logic                   m_valid_reg, m_valid_next;
    status_t                out_status_reg, out_status_next;
    logic [DATA_W-1:0]      out_data_reg, out_data_next;
    logic [INDEX_W-1:0]     out_idx_reg, out_idx_next;
    logic [INDEX_W-1:0]     out_total_reg, out_total_next;
    logic                   out_last_reg, out_last_next;

    logic [VALUE_WIDTH-1:0] cell_q [CAPACITY];
    cell_op_t               cell_ops [CAPACITY];

    logic                   out_free;
    logic [CMPW-1:0]        cnt_e, pos_e, cnt_m1, pos_m1;
    logic                   list_full, list_empty;
    logic                   do_ins, do_del, emit, start_trav;
    status_t                res_status;
    logic [IW-1:0]          tgt_idx, rd_idx;
    logic [VALUE_WIDTH-1:0] rd_val;
    logic [DW-1:0]          rd_ext, in_ext;
    logic                   exec_go, trav_go, trav_last;
    logic [CW-1:0]          trav_p1;
    logic [CMPW-1:0]        trav_e, total_e;

    assign out_free = !m_valid_reg || m_tready;

    assign cnt_e      = CMPW'(count_reg);
    assign pos_e      = CMPW'(pos_reg);
    assign cnt_m1     = cnt_e - CMPW'(1);
    assign pos_m1     = pos_e - CMPW'(1);
    assign list_full  = (cnt_e == CMPW'(CAPACITY));
    assign list_empty = (count_reg == '0);

    assign in_ext = DW'(s_tdata[DATA_W+OPCODE_W-1:OPCODE_W]);

    // Command decode, evaluated against the latched command and current count.
    always_comb begin
        do_ins     = 1'b0;
        do_del     = 1'b0;
        emit       = 1'b1;
        start_trav = 1'b0;
        res_status = ST_OK;
        tgt_idx    = '0;
        case (op_reg)
            OP_INS_FRONT: begin
                if (list_full) res_status = ST_FULL;
                else           do_ins = 1'b1;
            end
            OP_INS_BACK: begin
                tgt_idx = cnt_e[IW-1:0];
                if (list_full) res_status = ST_FULL;
                else           do_ins = 1'b1;
            end
            OP_INS_AT: begin
                // A list of fewer than two entries takes the value at its end.
                if (cnt_e < CMPW'(2)) begin
                    tgt_idx = cnt_e[IW-1:0];
                    do_ins  = 1'b1;
                end else if (pos_e <= CMPW'(1) || pos_e > cnt_e) begin
                    res_status = ST_BADPOS;
                end else if (list_full) begin
                    res_status = ST_FULL;
                end else begin
                    tgt_idx = pos_m1[IW-1:0];
                    do_ins  = 1'b1;
                end
            end
            OP_DEL_FRONT: begin
                if (list_empty) res_status = ST_EMPTY;
                else            do_del = 1'b1;
            end
            OP_DEL_BACK: begin
                tgt_idx = cnt_m1[IW-1:0];
                if (list_empty) res_status = ST_EMPTY;
                else            do_del = 1'b1;
            end
            OP_DEL_AT: begin
                if (list_empty) begin
                    res_status = ST_EMPTY;
                end else if (cnt_e <= CMPW'(2)) begin
                    res_status = ST_SHORT;
                end else if (pos_e <= CMPW'(1) || pos_e >= cnt_e) begin
                    res_status = ST_BADPOS;
                end else begin
                    tgt_idx = pos_m1[IW-1:0];
                    do_del  = 1'b1;
                end
            end
            OP_TRAVERSE: begin
                if (list_empty) begin
                    res_status = ST_EMPTY;
                end else begin
                    emit       = 1'b0;
                    start_trav = 1'b1;
                end
            end
            default: begin
                emit = 1'b0;
            end
        endcase
    end

    assign exec_go   = (state_reg == FSM_EXEC) && (out_free || !emit);
    assign trav_go   = (state_reg == FSM_TRAV) && out_free;
    assign trav_p1   = CW'(trav_reg) + CW'(1);
    assign trav_last = (trav_p1 == count_reg);
    assign trav_e    = CMPW'(trav_p1);

    // One read port into the cell row: the entry being removed or traversed.
    assign rd_idx = (state_reg == FSM_TRAV) ? trav_reg : tgt_idx;
    assign rd_val = cell_q[rd_idx];
    assign rd_ext = DW'(rd_val);

    genvar j;
    generate
        for (j = 0; j < CAPACITY; j++) begin : g_cells
            logic [VALUE_WIDTH-1:0] lower_value;
            logic [VALUE_WIDTH-1:0] upper_value;

            if (j == 0) begin : g_bottom
                assign lower_value = cell_q[0];
            end else begin : g_lower
                assign lower_value = cell_q[j-1];
            end
            if (j == CAPACITY - 1) begin : g_top
                assign upper_value = cell_q[CAPACITY-1];
            end else begin : g_upper
                assign upper_value = cell_q[j+1];
            end

            always_comb begin
                cell_ops[j] = CELL_HOLD;
                if (exec_go && do_ins) begin
                    if (IW'(j) > tgt_idx)       cell_ops[j] = CELL_SHIFT_UP;
                    else if (IW'(j) == tgt_idx) cell_ops[j] = CELL_LOAD;
                end else if (exec_go && do_del) begin
                    if (IW'(j) >= tgt_idx)      cell_ops[j] = CELL_SHIFT_DOWN;
                end
            end

            plst_cell #(
                .VALUE_WIDTH(VALUE_WIDTH)
            ) u_cell (
                .aclk       (aclk),
                .cell_op    (cell_ops[j]),
                .load_value (val_reg),
                .lower_value(lower_value),
                .upper_value(upper_value),
                .value_q    (cell_q[j])
            );
        end
    endgenerate

    // Next state.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            FSM_IDLE: begin
                if (s_tvalid) state_next = FSM_EXEC;
            end
            FSM_EXEC: begin
                if (exec_go) state_next = start_trav ? FSM_TRAV : FSM_IDLE;
            end
            FSM_TRAV: begin
                if (trav_go && trav_last) state_next = FSM_IDLE;
            end
            default: state_next = FSM_IDLE;
        endcase
    end

    assign total_e = CMPW'(count_next);

    // Datapath and output register updates.
    always_comb begin
        count_next      = count_reg;
        trav_next       = trav_reg;
        m_valid_next    = m_valid_reg && !m_tready;
        out_status_next = out_status_reg;
        out_data_next   = out_data_reg;
        out_idx_next    = out_idx_reg;
        out_last_next   = out_last_reg;
        case (state_reg)
            FSM_EXEC: begin
                trav_next = '0;
                if (exec_go) begin
                    if (do_ins) count_next = count_reg + CW'(1);
                    if (do_del) count_next = count_reg - CW'(1);
                    if (emit) begin
                        m_valid_next    = 1'b1;
                        out_status_next = res_status;
                        out_data_next   = do_del ? rd_ext[DATA_W-1:0] : '0;
                        out_idx_next    = '0;
                        out_last_next   = 1'b1;
                    end
                end
            end
            FSM_TRAV: begin
                if (trav_go) begin
                    trav_next       = trav_p1[IW-1:0];
                    m_valid_next    = 1'b1;
                    out_status_next = ST_OK;
                    out_data_next   = rd_ext[DATA_W-1:0];
                    out_idx_next    = trav_e[INDEX_W-1:0];
                    out_last_next   = trav_last;
                end
            end
            default: begin
            end
        endcase
        out_total_next = (exec_go || trav_go) ? total_e[INDEX_W-1:0] : out_total_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= FSM_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            op_reg  <= opcode_t'(s_tdata[OPCODE_W-1:0]);
            val_reg <= in_ext[VALUE_WIDTH-1:0];
            pos_reg <= s_tdata[S_TDATA_W-1:DATA_W+OPCODE_W];
        end
        trav_reg       <= trav_next;
        out_status_reg <= out_status_next;
        out_data_reg   <= out_data_next;
        out_idx_reg    <= out_idx_next;
        out_total_reg  <= out_total_next;
        out_last_reg   <= out_last_next;
    end

    assign s_tready = (state_reg == FSM_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {{(M_TDATA_W - STATUS_W - DATA_W - 2 * INDEX_W){1'b0}},
                       out_total_reg, out_idx_reg, out_data_reg, out_status_reg};

    // The list never holds more than its capacity.
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_e <= CMPW'(CAPACITY))
        else $error("entry count above capacity");

    // One command changes the count by at most one entry.
    a_count_step: assert property (@(posedge aclk) disable iff (!aresetn)
        ##1 (count_reg == $past(count_reg) || count_reg == $past(count_reg) + CW'(1) ||
             count_reg == $past(count_reg) - CW'(1)))
        else $error("entry count jumped");

    // An error status is always the only result of its command.
    a_error_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && out_status_reg != ST_OK) |-> out_last_reg)
        else $error("error result not marked last");

    // A traversal only walks over entries that are held.
    a_trav_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == FSM_TRAV) |-> (CW'(trav_reg) < count_reg))
        else $error("traversal index beyond list");

endmodule

`default_nettype wire

// File: dv/list_store_checker.sv
module list_store_checker #(
    parameter int CAPACITY = plst_pkg::DEF_CAPACITY
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    // s_tdata: opcode[2:0], item_value[34:3], list_position[39:35]
    input  logic [plst_pkg::S_TDATA_W-1:0] s_tdata,
    input  logic                           s_tvalid,
    input  logic                           s_tready,
    // m_tdata: status[2:0], data_out[34:3], entry_index[39:35], entry_total[44:40]
    input  logic [plst_pkg::M_TDATA_W-1:0] m_tdata,
    input  logic                           m_tlast,
    input  logic                           m_tvalid,
    input  logic                           m_tready,
    output int                             fail_count,
    output int                             results_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import plst_pkg::*;

    typedef struct packed {
        status_t              status;
        logic [DATA_W-1:0]    value;
        logic [INDEX_W-1:0]   index;
        logic [INDEX_W-1:0]   total;
        logic                 last;
    } list_result_t;

    logic [DATA_W-1:0] list_vals [CAPACITY];
    int                list_len = 0;
    list_result_t      result_queue [$];
    int                mismatches = 0;

    // The entry count recorded with each result is the one after the operation.
    function void store_result(status_t st, logic [DATA_W-1:0] v, int idx, logic last);
        list_result_t r;
        r.status = st;
        r.value  = v;
        r.index  = idx[INDEX_W-1:0];
        r.total  = list_len[INDEX_W-1:0];
        r.last   = last;
        result_queue.push_back(r);
    endfunction

    function void insert_entry(int at, logic [DATA_W-1:0] v);
        for (int j = list_len; j > at; j--)
            list_vals[j] = list_vals[j-1];
        list_vals[at] = v;
        list_len++;
    endfunction

    function logic [DATA_W-1:0] remove_entry(int at);
        logic [DATA_W-1:0] v;
        v = list_vals[at];
        for (int j = at; j + 1 < list_len; j++)
            list_vals[j] = list_vals[j+1];
        list_len--;
        return v;
    endfunction

    function void apply_list_op(logic [OPCODE_W-1:0] op, logic [DATA_W-1:0] v,
                                int pos);
        logic [DATA_W-1:0] gone;
        case (op)
            OP_INS_FRONT, OP_INS_BACK: begin
                if (list_len >= CAPACITY) begin
                    store_result(ST_FULL, '0, 0, 1'b1);
                end else begin
                    insert_entry(op == OP_INS_FRONT ? 0 : list_len, v);
                    store_result(ST_OK, '0, 0, 1'b1);
                end
            end
            OP_INS_AT: begin
                // A list this short takes the value at its back.
                if (list_len < 2) begin
                    insert_entry(list_len, v);
                    store_result(ST_OK, '0, 0, 1'b1);
                end else if (pos <= 1 || pos > list_len) begin
                    store_result(ST_BADPOS, '0, 0, 1'b1);
                end else if (list_len >= CAPACITY) begin
                    store_result(ST_FULL, '0, 0, 1'b1);
                end else begin
                    insert_entry(pos - 1, v);
                    store_result(ST_OK, '0, 0, 1'b1);
                end
            end
            OP_DEL_FRONT, OP_DEL_BACK: begin
                if (list_len == 0) begin
                    store_result(ST_EMPTY, '0, 0, 1'b1);
                end else begin
                    gone = remove_entry(op == OP_DEL_FRONT ? 0 : list_len - 1);
                    store_result(ST_OK, gone, 0, 1'b1);
                end
            end
            OP_DEL_AT: begin
                if (list_len == 0) begin
                    store_result(ST_EMPTY, '0, 0, 1'b1);
                end else if (list_len <= 2) begin
                    store_result(ST_SHORT, '0, 0, 1'b1);
                end else if (pos <= 1 || pos >= list_len) begin
                    store_result(ST_BADPOS, '0, 0, 1'b1);
                end else begin
                    gone = remove_entry(pos - 1);
                    store_result(ST_OK, gone, 0, 1'b1);
                end
            end
            OP_TRAVERSE: begin
                if (list_len == 0)
                    store_result(ST_EMPTY, '0, 0, 1'b1);
                else
                    for (int i = 0; i < list_len; i++)
                        store_result(ST_OK, list_vals[i], i + 1, i + 1 == list_len);
            end
            default: ;
        endcase
    endfunction

    function void check_field(string name, logic [DATA_W-1:0] want, logic [DATA_W-1:0] got);
        if (got !== want) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            mismatches++;
        end
    endfunction

    function void check_result();
        list_result_t want;
        if (result_queue.size() == 0) begin
            $error("result transfer with nothing expected: tdata %h tlast %b",
                   m_tdata, m_tlast);
            mismatches++;
        end else begin
            want = result_queue.pop_front();
            check_field("status", DATA_W'(want.status), DATA_W'(m_tdata[2:0]));
            check_field("data_out", want.value, m_tdata[34:3]);
            check_field("entry_index", DATA_W'(want.index), DATA_W'(m_tdata[39:35]));
            check_field("entry_total", DATA_W'(want.total), DATA_W'(m_tdata[44:40]));
            check_field("last_result", DATA_W'(want.last), DATA_W'(m_tlast));
        end
    endfunction

    // A result never comes out in the cycle its command goes in, so results
    // are compared before the new command is predicted.
    always @(posedge aclk) begin
        if (!aresetn) begin
            list_len = 0;
            result_queue.delete();
        end else begin
            if (m_tvalid && m_tready)
                check_result();
            if (s_tvalid && s_tready)
                apply_list_op(s_tdata[2:0], s_tdata[34:3], int'(s_tdata[39:35]));
        end
        fail_count      <= mismatches;
        results_pending <= result_queue.size();
    end

endmodule

// File: dv/testbench.sv
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import plst_pkg::*;

    localparam int RANDOM_OPS = 380;

    // The one opcode value that the block ignores.
    localparam logic [OPCODE_W-1:0] OP_UNUSED = 3'd7;

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 m_tlast;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;

    int                   fail_count;
    int                   results_pending;
    int                   burst_left = 0;
    logic [9:0]           stall_cycle = '0;

    positional_list_store dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready)
    );

    list_store_checker u_checker (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_tdata         (s_tdata),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .m_tdata         (m_tdata),
        .m_tlast         (m_tlast),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .fail_count      (fail_count),
        .results_pending (results_pending)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // The receiver cycles through always ready, a fixed one-in-three pattern,
    // random stalls and long periodic stalls.
    always @(posedge aclk) begin
        stall_cycle <= stall_cycle + 1'b1;
        case (stall_cycle[9:8])
            2'd0:    m_tready <= 1'b1;
            2'd1:    m_tready <= (stall_cycle % 3 == 0);
            2'd2:    m_tready <= ($urandom_range(0, 9) < 6);
            default: m_tready <= (stall_cycle[3:0] < 4'd11);
        endcase
    end

    // Holds the transfer until it is taken; the sender idles between bursts.
    task automatic send_op(logic [OPCODE_W-1:0] op, logic [DATA_W-1:0] v,
                           logic [POS_W-1:0] pos);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            gap        = $urandom_range(0, 5);
            if (gap != 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
        s_tdata  <= {pos, v, op};
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic drain_results();
        s_tvalid   <= 1'b0;
        burst_left = 0;
        @(posedge aclk);
        while (results_pending != 0) @(posedge aclk);
    endtask

    function automatic logic [DATA_W-1:0] pick_value();
        case ($urandom_range(0, 7))
            0:       return 32'h7fff_ffff;
            1:       return 32'h8000_0000;
            2:       return '0;
            3:       return '1;
            default: return $urandom;
        endcase
    endfunction

    // Mode 0 grows the list toward full, mode 1 shrinks it, mode 2 mixes.
    function automatic logic [OPCODE_W-1:0] pick_op(int mode);
        int r;
        r = $urandom_range(0, 99);
        if (r == 99)
            return OP_UNUSED;
        if (r < 10)
            return OP_TRAVERSE;
        r = $urandom_range(0, 99);
        if ((mode == 0 && r < 75) || (mode == 1 && r < 20) || (mode == 2 && r < 50))
            return opcode_t'($urandom_range(OP_INS_FRONT, OP_INS_AT));
        return opcode_t'($urandom_range(OP_DEL_FRONT, OP_DEL_AT));
    endfunction

    function automatic logic [POS_W-1:0] pick_position();
        if ($urandom_range(0, 9) < 7)
            return POS_W'($urandom_range(1, 17));
        return POS_W'($urandom_range(0, 31));
    endfunction

    initial begin
        int                  sent;
        int                  mode;
        int                  drain;
        logic [OPCODE_W-1:0] op;

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Empty list cases and the unused opcode.
        send_op(OP_TRAVERSE, 32'h1, 5'd0);
        send_op(OP_DEL_FRONT, 32'h2, 5'd1);
        send_op(OP_DEL_BACK, 32'h3, 5'd2);
        send_op(OP_DEL_AT, 32'h4, 5'd2);
        send_op(OP_UNUSED, 32'hdead_beef, 5'd31);
        // Positional inserts on short lists append whatever the position.
        send_op(OP_INS_AT, 32'h7fff_ffff, 5'd0);
        send_op(OP_DEL_AT, 32'h0, 5'd2);
        send_op(OP_INS_AT, 32'h8000_0000, 5'd31);
        send_op(OP_DEL_AT, 32'h0, 5'd1);
        send_op(OP_INS_FRONT, 32'hffff_ffff, 5'd0);
        // Bad and good positions around a list of three and four.
        send_op(OP_INS_AT, 32'h5, 5'd1);
        send_op(OP_INS_AT, 32'h6, 5'd4);
        send_op(OP_INS_AT, 32'h1234_5678, 5'd3);
        send_op(OP_DEL_AT, 32'h0, 5'd1);
        send_op(OP_DEL_AT, 32'h0, 5'd4);
        send_op(OP_DEL_AT, 32'h0, 5'd31);
        send_op(OP_DEL_AT, 32'h0, 5'd2);
        send_op(OP_TRAVERSE, 32'h0, 5'd0);
        send_op(OP_INS_BACK, 32'h0, 5'd0);
        send_op(OP_DEL_BACK, 32'h0, 5'd0);
        send_op(OP_DEL_FRONT, 32'h0, 5'd0);
        send_op(OP_TRAVERSE, 32'h0, 5'd0);
        drain_results();

        sent = 0;
        mode = 0;
        while (sent < RANDOM_OPS) begin
            if (sent % 24 == 0)
                mode = $urandom_range(0, 2);
            if (sent % 100 == 99)
                drain_results();
            op = pick_op(mode);
            send_op(op, pick_value(), pick_position());
            if (op != OP_UNUSED)
                sent++;
        end
        s_tvalid <= 1'b0;

        for (drain = 0; drain < 4000 && results_pending != 0; drain++)
            @(posedge aclk);
        repeat (40) @(posedge aclk);
        if (results_pending != 0)
            $error("%0d expected results never arrived", results_pending);
        if (fail_count == 0 && results_pending == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    initial begin
        #5_000_000;
        $display("tb: failure");
        $finish;
    end

endmodule
